FILE: hdl/tepq_pkg.sv
package tepq_pkg;

  // number of event slots
  localparam int QUEUE_DEPTH = 64;

  localparam int TIME_W  = 24;
  localparam int PROC_W  = 16;
  localparam int KIND_W  = 4;
  localparam int COUNT_W = 7;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    logic [PROC_W-1:0] ev_proc;
    logic [KIND_W-1:0] ev_kind;
  } slot_t;

endpackage

FILE: hdl/timed_event_priority_queue_unit.sv
// a transaction accepted into the input register (in_vld_r) shows its result
// strobe (out_valid) from the result register (out_valid_r)
// throughput: one transaction per cycle, busy is never raised; the receiver
// cannot stall, so the result is presented for exactly one cycle
// reset: synchronous active-low rst_n empties the queue and drops pending work;
// slot contents are left as they are and only slots below the count are read
module timed_event_priority_queue_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_opcode,
  input  logic [tepq_pkg::TIME_W-1:0]  in_event_time,
  input  logic [tepq_pkg::PROC_W-1:0]  in_process_number,
  input  logic [tepq_pkg::KIND_W-1:0]  in_event_kind,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [tepq_pkg::TIME_W-1:0]  out_time,
  output logic [tepq_pkg::PROC_W-1:0]  out_process,
  output logic [tepq_pkg::KIND_W-1:0]  out_kind,
  output logic [tepq_pkg::COUNT_W-1:0] out_entry_count
);
  import tepq_pkg::*;

  // ---------------------------------------------------------------------------
  // input register: one transaction captured per cycle
  // ---------------------------------------------------------------------------
  logic              in_vld_r;
  opcode_t           op_r;
  slot_t             ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start & ~busy;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r            <= opcode_t'(in_opcode);
      ev_r.ev_time    <= in_event_time;
      ev_r.ev_proc    <= in_process_number;
      ev_r.ev_kind    <= in_event_kind;
    end
  end

  // the queue update is combinational from the registered transaction, so no back-pressure is needed
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // sorted slot array, head at slot 0
  // ---------------------------------------------------------------------------
  slot_t             slot_r   [QUEUE_DEPTH];
  slot_t             slot_nxt [QUEUE_DEPTH];
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;

  logic                   full;
  logic                   empty;
  logic                   head_eq;
  logic [QUEUE_DEPTH-1:0] occ;     // slot holds a live event
  logic [QUEUE_DEPTH-1:0] ge;      // slot sits at or behind the insert point
  logic                   do_ins;
  logic                   do_rem;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  // a new event with the head's time goes right behind the head
  assign head_eq = !empty && (slot_r[0].ev_time == ev_r.ev_time);
  assign do_ins  = in_vld_r && (op_r == OP_INSERT) && !full;
  assign do_rem  = in_vld_r && (op_r == OP_REMOVE) && !empty;

  // per-slot compare, all slots in parallel; since the live slots are sorted
  // the ge mask is a suffix and its first set bit is the insert point
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      occ[i] = (CNT_W'(i) < cnt_r);
      if (head_eq) begin
        ge[i] = (i != 0);
      end else begin
        ge[i] = !occ[i] || !(slot_r[i].ev_time < ev_r.ev_time);
      end
    end
  end

  // shift-and-insert or shift-toward-head, one step for every slot
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    cnt_nxt = cnt_r;
    if (do_ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (ge[0]) begin
        slot_nxt[0] = ev_r;
      end
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (ge[i] && !ge[i-1]) begin
          slot_nxt[i] = ev_r;
        end else if (ge[i]) begin
          slot_nxt[i] = slot_r[i-1];
        end
      end
    end else if (do_rem) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        slot_nxt[i] = slot_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // slot storage is not cleared, entries past the count are never read
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  // ---------------------------------------------------------------------------
  // result register, strobed for one cycle
  // ---------------------------------------------------------------------------
  logic                 out_valid_r;
  status_t              status_r;
  status_t              status_nxt;
  slot_t                res_r;
  slot_t                res_nxt;
  logic [COUNT_W-1:0]   count_r;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  // entry count reports the occupancy after this transaction, held in full by COUNT_W bits
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_nxt};

  always_comb begin
    status_nxt = ST_OK;
    res_nxt    = '0;
    unique case (op_r)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          res_nxt = slot_r[0];
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      count_r  <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_time        = res_r.ev_time;
  assign out_process     = res_r.ev_proc;
  assign out_kind        = res_r.ev_kind;
  assign out_entry_count = count_r;

endmodule

FILE: hdl/tepq_checker.sv
module tepq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [1:0]                   out_status,
  input logic [tepq_pkg::TIME_W-1:0]  out_time,
  input logic [tepq_pkg::PROC_W-1:0]  out_process,
  input logic [tepq_pkg::KIND_W-1:0]  out_kind,
  input logic [tepq_pkg::COUNT_W-1:0] out_entry_count
);
  import tepq_pkg::*;

  // every accepted transaction produces its result strobe
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("missing result strobe");

  // no strobe without an earlier accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##2 !out_valid)
    else $error("result strobe without transaction");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_entry_count == '0))
    else $error("empty status with nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_entry_count == COUNT_W'(QUEUE_DEPTH)))
    else $error("full status with wrong count");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_time == '0 && out_process == '0 && out_kind == '0))
    else $error("error result carries event data");

endmodule

bind timed_event_priority_queue_unit tepq_checker u_tepq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_time        (out_time),
  .out_process     (out_process),
  .out_kind        (out_kind),
  .out_entry_count (out_entry_count)
);
